// ===== sv/ast_pkg.sv =====
// Package for the adaptive stream throttle: sizes, codes and reset values.
`timescale 1ns / 1ps
package ast_pkg;

	// Table and time sizes
	localparam int STREAMS   = 16;
	localparam int STREAM_W  = $clog2(STREAMS);
	localparam int TIME_BITS = 48;
	localparam int IVL_W     = 16;
	localparam int RUN_W     = 4;
	localparam int CFG_IDX_W = 3;

	// Largest value of the success run counter
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	// Reciprocal of ten for a 16-bit operand: (x * 52429) >> 19 is exact
	localparam logic [31:0] RECIP10       = 32'd52429;
	localparam int          RECIP10_SHIFT = 19;

	// Request kinds
	typedef enum logic [1:0] {
		REQ_CHECK     = 2'd0,
		REQ_SUCCESS   = 2'd1,
		REQ_THROTTLED = 2'd2,
		REQ_OTHER     = 2'd3
	} req_kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_BACKOFF  = 3'd0,
		CFG_MAX_BACKOFF      = 3'd1,
		CFG_PADDING_MIN      = 3'd2,
		CFG_SPEEDUP_COUNT    = 3'd3,
		CFG_SPEEDUP_MIN_STEP = 3'd4
	} cfg_reg_t;

	// Configuration reset values
	localparam logic [IVL_W-1:0] RST_INITIAL_BACKOFF  = 16'd500;
	localparam logic [IVL_W-1:0] RST_MAX_BACKOFF      = 16'd30000;
	localparam logic [IVL_W-1:0] RST_PADDING_MIN      = 16'd100;
	localparam logic [RUN_W-1:0] RST_SPEEDUP_COUNT    = 4'd8;
	localparam logic [IVL_W-1:0] RST_SPEEDUP_MIN_STEP = 16'd50;

	function automatic logic [IVL_W-1:0] max16(input logic [IVL_W-1:0] a,
						   input logic [IVL_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== sv/adaptive_stream_throttle.sv =====
// Adaptive stream throttle: per-stream interval table with one-pass update.
// Pipeline: input register, then result register.
// Throughput: one transaction per cycle unless out_stall holds a result; the per-stream
// table read-modify-write in the stage after the input register sets this figure.
// Reset (arst_n low, asynchronous): table entries cleared to zero, configuration
// registers return to their defaults, both pipeline stages empty.
`timescale 1ns / 1ps
module adaptive_stream_throttle (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	// Request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [3:0]                    stream_index,
	input  logic [47:0]                   now_ms,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          throttled,
	output logic                          suppressed,
	output logic [47:0]                   retry_time,
	output logic [15:0]                   interval_now
);
	import ast_pkg::*;

	// Configuration registers
	logic [IVL_W-1:0] init_bo_q, max_bo_q, pad_min_q, min_step_q;
	logic [RUN_W-1:0] spd_cnt_q;

	// Stream table
	logic [IVL_W-1:0]     ivl_q    [STREAMS];
	logic [RUN_W-1:0]     run_q    [STREAMS];
	logic [TIME_BITS-1:0] next_q   [STREAMS];
	logic [TIME_BITS-1:0] succ_q   [STREAMS];

	// Input stage
	logic                 valid_s1;
	req_kind_t            kind_s1;
	logic [3:0]           sidx_s1;
	logic [TIME_BITS-1:0] now_s1;

	// Result register
	logic                 out_valid_q;
	logic                 thr_q, sup_q;
	logic [47:0]          retry_q;
	logic [IVL_W-1:0]     ivl_out_q;

	logic advance;
	logic stream_ok;
	logic [STREAM_W-1:0] idx;

	// Entry being read and its next value
	logic [IVL_W-1:0]     cur_ivl, new_ivl;
	logic [RUN_W-1:0]     cur_run, new_run, run_inc, cnt_eff;
	logic [TIME_BITS-1:0] cur_next, new_next, cur_succ, new_succ;
	logic                 res_thr, res_sup;
	logic [TIME_BITS-1:0] res_retry;

	// Arithmetic helpers
	logic [31:0]          div10_prod;
	logic [IVL_W-1:0]     div10, step, shrunk;
	logic [IVL_W:0]       grow, padded, cand_b;
	logic [IVL_W-1:0]     cand_a, cand, obs;
	logic [TIME_BITS-1:0] gap;
	logic                 gap_ok;

	assign cfg_ready = 1'b1;

	// Handshake: result register frees when empty or taken
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	assign throttled    = thr_q;
	assign suppressed   = sup_q;
	assign retry_time   = retry_q;
	assign interval_now = ivl_out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_bo_q  <= RST_INITIAL_BACKOFF;
			max_bo_q   <= RST_MAX_BACKOFF;
			pad_min_q  <= RST_PADDING_MIN;
			spd_cnt_q  <= RST_SPEEDUP_COUNT;
			min_step_q <= RST_SPEEDUP_MIN_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_INITIAL_BACKOFF:  init_bo_q  <= cfg_data;
				CFG_MAX_BACKOFF:      max_bo_q   <= cfg_data;
				CFG_PADDING_MIN:      pad_min_q  <= cfg_data;
				CFG_SPEEDUP_COUNT:    spd_cnt_q  <= cfg_data[RUN_W-1:0];
				CFG_SPEEDUP_MIN_STEP: min_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1 <= req_kind_t'(req_type);
			sidx_s1 <= stream_index;
			now_s1  <= TIME_BITS'(now_ms);
		end
	end

	assign stream_ok = (32'(sidx_s1) < STREAMS);
	assign idx       = sidx_s1[STREAM_W-1:0];

	// Table read
	assign cur_ivl  = ivl_q[idx];
	assign cur_run  = run_q[idx];
	assign cur_next = next_q[idx];
	assign cur_succ = succ_q[idx];

	// Divide by ten through the reciprocal
	assign div10_prod = 32'(cur_ivl) * RECIP10;
	assign div10      = IVL_W'(div10_prod >> RECIP10_SHIFT);

	// Shrink path for a completed success run
	assign run_inc = (cur_run == RUN_MAX) ? RUN_MAX : cur_run + 1'b1;
	assign cnt_eff = (spd_cnt_q == '0) ? RUN_W'(1) : spd_cnt_q;
	assign step    = max16(min_step_q, div10);
	assign shrunk  = (cur_ivl > step) ? cur_ivl - step : '0;

	// Grow path: half the interval or the padding, clamped; zero takes the initial backoff
	assign grow   = {1'b0, cur_ivl} + {1'b0, max16(pad_min_q, {1'b0, cur_ivl[IVL_W-1:1]})};
	assign cand_a = (cur_ivl == '0) ? init_bo_q
		      : ((grow > {1'b0, max_bo_q}) ? max_bo_q : grow[IVL_W-1:0]);

	// Observed gap since last success, saturated, plus a quarter or the padding
	assign gap    = now_s1 - cur_succ;
	assign gap_ok = (cur_succ != '0) && (now_s1 > cur_succ);
	assign obs    = (gap > TIME_BITS'(max_bo_q)) ? max_bo_q : gap[IVL_W-1:0];
	assign padded = {1'b0, obs} + {1'b0, max16(pad_min_q, {2'b00, obs[IVL_W-1:2]})};
	assign cand_b = (gap_ok && (padded > {1'b0, cand_a})) ? padded : {1'b0, cand_a};
	assign cand   = (cand_b > {1'b0, max_bo_q}) ? max_bo_q : cand_b[IVL_W-1:0];

	// Per-kind update of the entry and the result
	always_comb begin
		new_ivl   = cur_ivl;
		new_run   = cur_run;
		new_next  = cur_next;
		new_succ  = cur_succ;
		res_thr   = 1'b0;
		res_sup   = 1'b0;
		res_retry = '0;
		case (kind_s1)
			REQ_CHECK: begin
				if (now_s1 < cur_next) begin
					res_thr   = 1'b1;
					res_sup   = 1'b1;
					res_retry = cur_next;
				end
			end
			REQ_SUCCESS: begin
				new_succ = now_s1;
				if (cur_ivl != '0) begin
					if (run_inc >= cnt_eff) begin
						new_ivl  = shrunk;
						new_run  = '0;
						new_next = now_s1 + TIME_BITS'(shrunk);
					end else begin
						new_run  = run_inc;
						new_next = now_s1 + TIME_BITS'(cur_ivl);
					end
				end else begin
					new_run  = '0;
					new_next = '0;
				end
			end
			REQ_THROTTLED: begin
				new_ivl   = cand;
				new_run   = '0;
				new_next  = now_s1 + TIME_BITS'(cand);
				res_thr   = 1'b1;
				res_retry = now_s1 + TIME_BITS'(cand);
			end
			default: ;
		endcase
	end

	// Table write, one entry per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STREAMS; i++) begin
				ivl_q[i]  <= '0;
				run_q[i]  <= '0;
				next_q[i] <= '0;
				succ_q[i] <= '0;
			end
		end else if (advance && valid_s1 && stream_ok) begin
			ivl_q[idx]  <= new_ivl;
			run_q[idx]  <= new_run;
			next_q[idx] <= new_next;
			succ_q[idx] <= new_succ;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload; out-of-range streams give all zeros
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			thr_q     <= stream_ok & res_thr;
			sup_q     <= stream_ok & res_sup;
			retry_q   <= stream_ok ? 48'(res_retry) : '0;
			ivl_out_q <= stream_ok ? new_ivl : '0;
		end
	end

endmodule

// ===== sv/ast_checker.sv =====
// Port-level checker for the adaptive stream throttle, bound to the top level.
`timescale 1ns / 1ps
module ast_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        throttled,
	input logic        suppressed,
	input logic [47:0] retry_time,
	input logic [15:0] interval_now
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(retry_time) && $stable(interval_now)
			&& $stable(throttled) && $stable(suppressed))
		else $error("result payload changed while stalled");

	// Suppression is always reported as throttled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> throttled)
		else $error("suppressed without throttled");

	// A suppressed check points at a future time, never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> retry_time != 48'd0)
		else $error("suppressed with zero retry time");

	// Without throttling there is no retry time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !throttled |-> retry_time == 48'd0)
		else $error("retry time given without throttling");

endmodule

bind adaptive_stream_throttle ast_checker u_ast_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.throttled    (throttled),
	.suppressed   (suppressed),
	.retry_time   (retry_time),
	.interval_now (interval_now)
);
